### src/rsps_pkg.sv
// Shared types, codes and constants of the ramp/soak profile simulator.
// No dependencies; used by the top level and the setpoint RAM.
package rsps_pkg;

  localparam int unsigned MAX_STEPS_DEF = 16;
  localparam int unsigned TEMP_W        = 14;
  localparam int unsigned STEP_W        = 5;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 16;

  localparam int TEMP_MIN  = -1000;
  localparam int TEMP_MAX  = 5000;
  localparam int TEMP_HOME = 250;
  localparam int TOLERANCE = 10;

  localparam int unsigned QDEPTH      = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;
  localparam int unsigned MAX_RESULTS = 2;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;
  localparam logic [1:0] CMD_STOP  = 2'd3;

  localparam logic [1:0] KIND_READING = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_START   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_RATE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_RATE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SOAK_TICKS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PROFILE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MARKER_MODE    = 3'd5;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [TEMP_W-1:0] temp;
    logic [3:0]               step;
    logic                     last;
  } result_t;

  function automatic result_t make_result(logic [1:0] k, logic signed [TEMP_W-1:0] t,
                                          logic [STEP_W-1:0] idx);
    result_t r;
    r.kind = k;
    r.temp = t;
    r.step = idx[3:0];
    r.last = 1'b0;
    return r;
  endfunction

endpackage

### src/rsps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on rsps_pkg for default sizes.
module rsps_ram import rsps_pkg::*; #(
  parameter int unsigned WIDTH = TEMP_W,
  parameter int unsigned DEPTH = MAX_STEPS_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/ramp_soak_profile_sim.sv
// Ramp/soak profile simulator top level: config registers, tick/step logic,
// setpoint RAM prefetch with write forwarding, result queue. Uses rsps_pkg, rsps_ram.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------
//  config  | cfg_write             | cfg_index, cfg_data
//  request | req_valid / req_ready | command, step_slot, setpoint_value
//  result  | res_valid / res_ready | kind, temperature, step_now, last
//
// One request per cycle while req_ready is high; a request's results enter the queue at its accept edge.
// The setpoint of the step in force is prefetched from the RAM; when the clamped step
// changes outside request flow (step_count rewritten), req_ready drops for a refetch.
// req_ready drops while fewer than two of the four result queue entries are free.
// Synchronous reset clears control state; the setpoint RAM is not cleared.
module ramp_soak_profile_sim import rsps_pkg::*; #(
  parameter int unsigned MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     req_valid,
  output logic                     req_ready,
  input  logic [1:0]               command,
  input  logic [3:0]               step_slot,
  input  logic signed [TEMP_W-1:0] setpoint_value,
  output logic                     res_valid,
  input  logic                     res_ready,
  output logic [1:0]               kind,
  output logic signed [TEMP_W-1:0] temperature,
  output logic [3:0]               step_now,
  output logic                     last
);

  localparam int unsigned AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam logic signed [TEMP_W:0]   TMIN_X = (TEMP_W+1)'(TEMP_MIN);
  localparam logic signed [TEMP_W:0]   TMAX_X = (TEMP_W+1)'(TEMP_MAX);
  localparam logic signed [TEMP_W:0]   TOL_X  = (TEMP_W+1)'(TOLERANCE);
  localparam logic signed [TEMP_W-1:0] HOME_T = TEMP_W'(TEMP_HOME);

  logic [4:0]  step_count;
  logic [9:0]  rise_rate;
  logic [9:0]  fall_rate;
  logic [15:0] soak_ticks;
  logic        repeat_profile;
  logic        marker_mode;

  logic signed [TEMP_W-1:0] temp_now, temp_next;
  logic [STEP_W-1:0]        step_index, step_index_next;
  logic                     stable_flag, stable_flag_next;
  logic [15:0]              soak_counter, soak_counter_next;
  logic                     running, running_next;

  logic [STEP_W-1:0] cnt, eidx, nidx, rd_idx;
  logic              stall, req_fire;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [TEMP_W-1:0]        ram_rdata;
  logic                     fwd_hit;
  logic signed [TEMP_W-1:0] fwd_data;
  logic signed [TEMP_W-1:0] sp;

  logic signed [TEMP_W:0] temp_x, diff, tmp_up, tmp_dn;
  logic                   in_band;

  result_t   r0, r1;
  logic [1:0] push_n;
  logic       emit_read;

  result_t             q_mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   q_count;
  logic                pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_count     <= 5'd5;
      rise_rate      <= 10'd10;
      fall_rate      <= 10'd10;
      soak_ticks     <= 16'd5;
      repeat_profile <= 1'b1;
      marker_mode    <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_STEP_COUNT:     step_count     <= cfg_data[4:0];
        CFG_RISE_RATE:      rise_rate      <= cfg_data[9:0];
        CFG_FALL_RATE:      fall_rate      <= cfg_data[9:0];
        CFG_SOAK_TICKS:     soak_ticks     <= cfg_data[15:0];
        CFG_REPEAT_PROFILE: repeat_profile <= cfg_data[0];
        CFG_MARKER_MODE:    marker_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (step_count == 5'd0) begin
      cnt = 5'd1;
    end else if (32'(step_count) > MAX_STEPS) begin
      cnt = STEP_W'(MAX_STEPS);
    end else begin
      cnt = step_count;
    end
  end

  assign eidx      = (step_index >= cnt) ? cnt - 5'd1 : step_index;
  assign stall     = (rd_idx != eidx);
  assign req_ready = !stall && (q_count <= QCNT_W'(QDEPTH - MAX_RESULTS));
  assign req_fire  = req_valid && req_ready;
  assign pop       = res_valid && res_ready;

  assign sp      = fwd_hit ? fwd_data : $signed(ram_rdata);
  assign temp_x  = $signed({temp_now[TEMP_W-1], temp_now});
  assign diff    = temp_x - $signed({sp[TEMP_W-1], sp});
  assign in_band = (diff > -TOL_X) && (diff < TOL_X);
  assign tmp_up  = temp_x + $signed({5'b0, rise_rate});
  assign tmp_dn  = temp_x - $signed({5'b0, fall_rate});

  always_comb begin
    temp_next         = temp_now;
    step_index_next   = step_index;
    stable_flag_next  = stable_flag;
    soak_counter_next = soak_counter;
    running_next      = running;
    ram_we            = 1'b0;
    r0                = '0;
    r1                = '0;
    push_n            = 2'd0;
    emit_read         = 1'b0;
    if (req_fire) begin
      unique case (command)
        CMD_LOAD: begin
          ram_we = (32'(step_slot) < MAX_STEPS);
        end
        CMD_START: begin
          step_index_next   = '0;
          temp_next         = HOME_T;
          stable_flag_next  = 1'b0;
          soak_counter_next = '0;
          running_next      = 1'b1;
          if (marker_mode) begin
            r0     = make_result(KIND_START, HOME_T, '0);
            push_n = 2'd1;
          end
        end
        CMD_STOP: begin
          if (running) begin
            running_next = 1'b0;
            if (marker_mode) begin
              r0     = make_result(KIND_END, temp_now, step_index);
              push_n = 2'd1;
            end
          end
        end
        CMD_TICK: begin
          if (running) begin
            step_index_next = eidx;
            emit_read       = 1'b1;
            if (in_band) begin
              if (!stable_flag) begin
                stable_flag_next  = 1'b1;
                soak_counter_next = '0;
              end else if (soak_counter >= soak_ticks) begin
                stable_flag_next  = 1'b0;
                soak_counter_next = '0;
                if (eidx == cnt - 5'd1) begin
                  if (repeat_profile) begin
                    step_index_next = '0;
                    emit_read       = 1'b0;
                    if (marker_mode) begin
                      r0        = make_result(KIND_END, temp_now, '0);
                      temp_next = HOME_T;
                      r1        = make_result(KIND_START, HOME_T, '0);
                      push_n    = 2'd2;
                    end
                  end else begin
                    running_next = 1'b0;
                    if (marker_mode) begin
                      r0     = make_result(KIND_END, temp_now, eidx);
                      push_n = 2'd1;
                    end
                  end
                end else begin
                  step_index_next = eidx + 5'd1;
                end
              end else begin
                soak_counter_next = soak_counter + 16'd1;
              end
            end else if (diff > 0) begin
              temp_next         = TEMP_W'((tmp_dn < TMIN_X) ? TMIN_X : tmp_dn);
              stable_flag_next  = 1'b0;
              soak_counter_next = '0;
            end else begin
              temp_next         = TEMP_W'((tmp_up > TMAX_X) ? TMAX_X : tmp_up);
              stable_flag_next  = 1'b0;
              soak_counter_next = '0;
            end
          end
        end
        default: ;
      endcase
    end
    if (emit_read) begin
      if (push_n == 2'd0) begin
        r0 = make_result(KIND_READING, temp_next, step_index_next);
      end else begin
        r1 = make_result(KIND_READING, temp_next, step_index_next);
      end
      push_n = push_n + 2'd1;
    end
    if (push_n == 2'd1) begin
      r0.last = 1'b1;
    end
    if (push_n == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_now     <= HOME_T;
      step_index   <= '0;
      stable_flag  <= 1'b0;
      soak_counter <= '0;
      running      <= 1'b0;
    end else begin
      temp_now     <= temp_next;
      step_index   <= step_index_next;
      stable_flag  <= stable_flag_next;
      soak_counter <= soak_counter_next;
      running      <= running_next;
    end
  end

  // prefetch the setpoint of the step in force after this edge
  assign nidx      = (step_index_next >= cnt) ? cnt - 5'd1 : step_index_next;
  assign ram_raddr = AW'(nidx);
  assign ram_waddr = AW'(step_slot);

  rsps_ram #(
    .WIDTH (TEMP_W),
    .DEPTH (MAX_STEPS)
  ) u_setpoints (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (setpoint_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx  <= '0;
      fwd_hit <= 1'b0;
    end else begin
      rd_idx  <= nidx;
      fwd_hit <= ram_we && (ram_waddr == ram_raddr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= setpoint_value;
  end

  // result queue
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_mem[wr_ptr] <= r0;
    end
    if (push_n == 2'd2) begin
      q_mem[wr_ptr + QPTR_W'(1)] <= r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      wr_ptr  <= wr_ptr + QPTR_W'(push_n);
      rd_ptr  <= rd_ptr + QPTR_W'(pop);
      q_count <= q_count + QCNT_W'(push_n) - QCNT_W'(pop);
    end
  end

  assign res_valid   = (q_count != '0);
  assign kind        = q_mem[rd_ptr].kind;
  assign temperature = q_mem[rd_ptr].temp;
  assign step_now    = q_mem[rd_ptr].step;
  assign last        = q_mem[rd_ptr].last;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    ($signed({temp_now[TEMP_W-1], temp_now}) >= TMIN_X) &&
    ($signed({temp_now[TEMP_W-1], temp_now}) <= TMAX_X))
    else $error("temperature out of range");

  a_step_clamped: assert property (@(posedge clk) disable iff (rst)
    req_fire && (command == CMD_TICK) && running |=> step_index < $past(cnt))
    else $error("step index beyond steps in use after tick");

  a_no_marker: assert property (@(posedge clk) disable iff (rst)
    (push_n != 2'd0) && !marker_mode |-> (push_n == 2'd1) && (r0.kind == KIND_READING))
    else $error("marker pushed with markers off");

endmodule
